### rtl/sdcq_pkg.sv
// ----------------------------------------------------------------------------
// sdcq_pkg
// Shared types and constants of the sorted cell queue with duplicate drop.
// ----------------------------------------------------------------------------
package sdcq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 2;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 8;
  localparam int HND_W    = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [HND_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  typedef struct packed {
    logic             popped_valid;
    logic [ROW_W-1:0] popped_row;
    logic [COL_W-1:0] popped_col;
    logic [HND_W-1:0] popped_handle;
    logic             duplicate_dropped;
    logic             overflow_dropped;
    logic [CNT_W-1:0] entry_count;
  } res_t;

endpackage

### rtl/sdcq_if.sv
// ----------------------------------------------------------------------------
// sdcq interfaces
// Command and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdcq_cmd_if;
  import sdcq_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ROW_W-1:0] row_key;
  logic [COL_W-1:0] col_key;
  logic [HND_W-1:0] node_handle;

  modport source (output valid, command, row_key, col_key, node_handle, input ready);
  modport sink   (input valid, command, row_key, col_key, node_handle, output ready);
endinterface

interface sdcq_res_if;
  import sdcq_pkg::*;

  logic             valid;
  logic             ready;
  logic             popped_valid;
  logic [ROW_W-1:0] popped_row;
  logic [COL_W-1:0] popped_col;
  logic [HND_W-1:0] popped_handle;
  logic             duplicate_dropped;
  logic             overflow_dropped;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, popped_valid, popped_row, popped_col, popped_handle,
                  duplicate_dropped, overflow_dropped, entry_count, input ready);
  modport sink   (input valid, popped_valid, popped_row, popped_col, popped_handle,
                  duplicate_dropped, overflow_dropped, entry_count, output ready);
endinterface

### rtl/sdcq_ram.sv
// ----------------------------------------------------------------------------
// sdcq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdcq_ram (
  input  logic              clk_i,
  input  sdcq_pkg::mem_req_t req_i,
  output sdcq_pkg::entry_t   rdata_o
);
  import sdcq_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sdcq_ctrl.sv
// ----------------------------------------------------------------------------
// sdcq_ctrl
// Sequencer: search, shift and pop walks over the entry store.
// Entries sit in ascending key order, so the greatest key is at count - 1.
// ----------------------------------------------------------------------------
module sdcq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  sdcq_cmd_if.sink           cmd_i,
  output sdcq_pkg::mem_req_t mem_req_o,
  input  sdcq_pkg::entry_t   mem_rdata_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output sdcq_pkg::res_t     res_o
);
  import sdcq_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SRCH     = 3'd1;
  localparam logic [2:0] ST_SRCH_CMP = 3'd2;
  localparam logic [2:0] ST_DECIDE   = 3'd3;
  localparam logic [2:0] ST_SHIFT    = 3'd4;
  localparam logic [2:0] ST_SHIFT_WR = 3'd5;
  localparam logic [2:0] ST_POP_DAT  = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  entry_t           new_q, new_d;
  res_t             res_q, res_d;
  mem_req_t         mem_req;

  logic [CNT_W-1:0]       idx_m1;
  logic [CNT_W-1:0]       occ_m1;
  logic [ROW_W+COL_W-1:0] st_key;
  logic [ROW_W+COL_W-1:0] new_key;

  assign idx_m1  = idx_q - 1'b1;
  assign occ_m1  = occ_q - 1'b1;
  assign st_key  = {mem_rdata_i.row, mem_rdata_i.col};
  assign new_key = {new_q.row, new_q.col};

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    new_d   = new_q;
    res_d   = res_q;
    mem_req = '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          res_d      = '0;
          new_d.row    = cmd_i.row_key;
          new_d.col    = cmd_i.col_key;
          new_d.handle = cmd_i.node_handle;
          case (cmd_e'(cmd_i.command))
            CMD_INSERT: begin
              idx_d   = occ_q;
              state_d = ST_SRCH;
            end
            CMD_POP: begin
              if (occ_q == '0) begin
                state_d = ST_DONE;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = occ_m1[ADDR_W-1:0];
                state_d         = ST_POP_DAT;
              end
            end
            CMD_CLEAR: begin
              occ_d   = '0;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      // walk down from the greatest key until one is not greater
      ST_SRCH: begin
        if (idx_q == '0) begin
          pos_d   = '0;
          state_d = ST_DECIDE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_m1[ADDR_W-1:0];
          state_d         = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (st_key > new_key) begin
          idx_d   = idx_m1;
          state_d = ST_SRCH;
        end else if (st_key == new_key) begin
          res_d.duplicate_dropped = 1'b1;
          state_d                 = ST_DONE;
        end else begin
          pos_d   = idx_q;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (occ_q == CNT_W'(CAPACITY)) begin
          res_d.overflow_dropped = 1'b1;
          state_d                = ST_DONE;
        end else begin
          idx_d   = occ_q;
          state_d = ST_SHIFT;
        end
      end
      // move greater entries up one slot, then drop the new one into the gap
      ST_SHIFT: begin
        if (idx_q == pos_q) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_q[ADDR_W-1:0];
          mem_req.wr_data = new_q;
          occ_d           = occ_q + 1'b1;
          state_d         = ST_DONE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_m1[ADDR_W-1:0];
          state_d         = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx_q[ADDR_W-1:0];
        mem_req.wr_data = mem_rdata_i;
        idx_d           = idx_m1;
        state_d         = ST_SHIFT;
      end
      ST_POP_DAT: begin
        res_d.popped_valid  = 1'b1;
        res_d.popped_row    = mem_rdata_i.row;
        res_d.popped_col    = mem_rdata_i.col;
        res_d.popped_handle = mem_rdata_i.handle;
        occ_d               = occ_m1;
        state_d             = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    new_q <= new_d;
    res_q <= res_d;
  end

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign mem_req_o   = mem_req;
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_o             = res_q;
    res_o.entry_count = occ_q;
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_occ_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(occ_q) |-> state_q == ST_DONE)
    else $error("occupancy changed outside completion of a transaction");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> occ_q < CNT_W'(CAPACITY))
    else $error("store written while full");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT |-> pos_q <= idx_q)
    else $error("shift walked past insert position");
`endif

endmodule

### rtl/sorted_dedup_cell_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_dedup_cell_queue_core
// Bounded sorted queue of (row, column) keyed cell nodes, duplicates dropped.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command per transaction: insert (key and handle),
//   pop of the greatest key, or clear. res_o returns exactly one result per
//   command: the popped entry if any, the duplicate and overflow flags and
//   the entry count after the command.
//   Steps per command: clear, an unused code or a pop of an empty queue goes
//   straight to the result; a pop reads the greatest entry. An insert first
//   searches down from the greatest key past every stored key greater than
//   the new one, then moves those entries up one slot each and writes the new
//   entry into the gap. A duplicate ends the search with the duplicate flag;
//   a full store is found after the search and sets the overflow flag.
//   Each step of the search and shift walks reads the entry memory and then
//   uses its registered read data.
//   One command is in work at a time; cmd_i is ready again as soon as the
//   result has moved into the output register, even if res_o is stalled.
//   A stalled res_o holds its result; when a second result is finished the
//   sequencer waits for the register to drain.
//   Reset empties the queue at once (the count clears; stored entries are
//   not swept) and leaves res_o without a valid result.
// ----------------------------------------------------------------------------
module sorted_dedup_cell_queue_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdcq_cmd_if.sink  cmd_i,
  sdcq_res_if.source res_o
);
  import sdcq_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     res_valid;
  logic     res_ready;
  res_t     res;
  res_t     out_q;
  logic     out_valid_q;

  sdcq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  sdcq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register: load when empty or draining this cycle
  assign res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.popped_valid      = out_q.popped_valid;
  assign res_o.popped_row        = out_q.popped_row;
  assign res_o.popped_col        = out_q.popped_col;
  assign res_o.popped_handle     = out_q.popped_handle;
  assign res_o.duplicate_dropped = out_q.duplicate_dropped;
  assign res_o.overflow_dropped  = out_q.overflow_dropped;
  assign res_o.entry_count       = out_q.entry_count;

endmodule
